/* hdl/tri3d_pkg.sv */
// Shared constants, codes and command/status types for the 3D grid interpolator.
package tri3d_pkg;

  // Grid shape
  localparam int POINTS_A = 16;
  localparam int POINTS_B = 16;
  localparam int POINTS_C = 16;
  localparam int STRIDE_A = POINTS_B * POINTS_C;
  localparam int STRIDE_B = POINTS_C;

  // Table and datapath widths
  localparam int ADDR_W   = 12;
  localparam int DEPTH    = 4096;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 8;
  localparam int W_W      = 48;
  localparam int DIFF_W   = 33;
  localparam int HALF_W   = 24;
  localparam int PROD_W   = 57;
  localparam int SUM_W    = 58;
  localparam int CORNERS  = 8;
  localparam int QCNT_W   = 4;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_START_A = 3'd0,
    REG_START_B = 3'd1,
    REG_START_C = 3'd2,
    REG_INV_A   = 3'd3,
    REG_INV_B   = 3'd4,
    REG_INV_C   = 3'd5
  } reg_idx_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BELOW = 2'd1,
    STATUS_SAT   = 2'd2,
    STATUS_WRITE = 2'd3
  } status_t;

  // Item kinds
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    AX_A = 2'd0,
    AX_B = 2'd1,
    AX_C = 2'd2
  } axis_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_AXMUL,
    ST_AXEVAL,
    ST_FETCH,
    ST_LPREP,
    ST_LMULLO,
    ST_LMULHI,
    ST_LSUM,
    ST_LACC,
    ST_FINISH,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       mem_wr;
    logic       ax_mul;
    logic       ax_eval;
    axis_t      axis;
    logic       rd_en;
    logic [2:0] corner;
    logic       push;
    logic       l_prep;
    logic       l_mullo;
    logic       l_mulhi;
    logic       l_sum;
    logic       l_acc;
    axis_t      w_sel;
    logic       finish;
  } tri_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic below;
  } tri_stat_t;

endpackage

/* hdl/tri3d_ctrl.sv */
// Sequencer for table writes, axis setup, corner fetches and the seven lerps.
module tri3d_ctrl
  import tri3d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      kind,
  input  tri_stat_t stat,
  output tri_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  state_t      state, state_next;
  axis_t       axis_cnt;
  logic [3:0]  fetch_cnt;
  logic [2:0]  lerp_cnt;
  logic        accept;

  assign busy   = !(state == ST_IDLE || state == ST_DONE);
  assign done   = (state == ST_DONE);
  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          state_next = (kind == KIND_QUERY) ? ST_AXMUL : ST_WRITE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WRITE:  state_next = ST_FINISH;
      ST_AXMUL:  state_next = ST_AXEVAL;
      ST_AXEVAL: begin
        if (axis_cnt == AX_C) begin
          state_next = stat.below ? ST_FINISH : ST_FETCH;
        end else begin
          state_next = ST_AXMUL;
        end
      end
      ST_FETCH: begin
        if (fetch_cnt == 4'(CORNERS)) begin
          state_next = ST_LPREP;
        end
      end
      ST_LPREP:  state_next = ST_LMULLO;
      ST_LMULLO: state_next = ST_LMULHI;
      ST_LMULHI: state_next = ST_LSUM;
      ST_LSUM:   state_next = ST_LACC;
      ST_LACC:   state_next = (lerp_cnt == 3'd6) ? ST_FINISH : ST_LPREP;
      ST_FINISH: state_next = ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd         = '0;
    cmd.axis    = axis_cnt;
    cmd.corner  = fetch_cnt[2:0];
    cmd.accept  = accept;
    cmd.w_sel   = (lerp_cnt inside {[3'd0:3'd3]}) ? AX_A :
                  (lerp_cnt inside {[3'd4:3'd5]}) ? AX_B : AX_C;
    case (state)
      ST_WRITE:  cmd.mem_wr  = 1'b1;
      ST_AXMUL:  cmd.ax_mul  = 1'b1;
      ST_AXEVAL: cmd.ax_eval = 1'b1;
      ST_FETCH: begin
        cmd.rd_en = (fetch_cnt < 4'(CORNERS));
        cmd.push  = (fetch_cnt != 4'd0);
      end
      ST_LPREP:  cmd.l_prep  = 1'b1;
      ST_LMULLO: cmd.l_mullo = 1'b1;
      ST_LMULHI: cmd.l_mulhi = 1'b1;
      ST_LSUM:   cmd.l_sum   = 1'b1;
      ST_LACC:   cmd.l_acc   = 1'b1;
      ST_FINISH: cmd.finish  = 1'b1;
      default:   cmd.finish  = 1'b0;
    endcase
  end

  // State and step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis_cnt  <= AX_A;
      fetch_cnt <= '0;
      lerp_cnt  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        axis_cnt  <= AX_A;
        fetch_cnt <= '0;
        lerp_cnt  <= '0;
      end else begin
        if (state == ST_AXEVAL && axis_cnt != AX_C) begin
          axis_cnt <= axis_t'(axis_cnt + 2'd1);
        end
        // hold the count at the last step so it stays in range
        if (state == ST_FETCH && fetch_cnt != 4'(CORNERS)) begin
          fetch_cnt <= fetch_cnt + 4'd1;
        end
        if (state == ST_LACC) begin
          lerp_cnt <= lerp_cnt + 3'd1;
        end
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted beat did not make the block busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held for more than one cycle");
  a_fetch_bound: assert property (@(posedge clk) disable iff (rst)
    fetch_cnt <= 4'(CORNERS)) else $error("corner fetch count overran");
  a_busy_nodone: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |=> done) else $error("finish not followed by strobe");

endmodule

/* hdl/tri3d_dp.sv */
// Datapath: configuration, grid memory, axis mapping, corner queue and lerp unit.
module tri3d_dp
  import tri3d_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  tri_cmd_t                 cmd,
  output tri_stat_t                stat,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     kind,
  input  logic [ADDR_W-1:0]        entry_address,
  input  logic signed [DATA_W-1:0] entry_value,
  input  logic signed [DATA_W-1:0] coord_a,
  input  logic signed [DATA_W-1:0] coord_b,
  input  logic signed [DATA_W-1:0] coord_c,
  output logic signed [DATA_W-1:0] result_value,
  output logic [1:0]               status
);

  localparam logic signed [DATA_W+1:0] MAX_V = 34'sd2147483647;
  localparam logic signed [DATA_W+1:0] MIN_V = -34'sd2147483648;

  // Configuration registers
  logic signed [DATA_W-1:0] start_a, start_b, start_c;
  logic [DATA_W-1:0]        inv_a, inv_b, inv_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_a <= '0;
      start_b <= '0;
      start_c <= '0;
      inv_a   <= 32'd65536;
      inv_b   <= 32'd65536;
      inv_c   <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_A: start_a <= cfg_data;
        REG_START_B: start_b <= cfg_data;
        REG_START_C: start_c <= cfg_data;
        REG_INV_A:   inv_a   <= cfg_data;
        REG_INV_B:   inv_b   <= cfg_data;
        REG_INV_C:   inv_c   <= cfg_data;
        default:     inv_c   <= inv_c;
      endcase
    end
  end

  // Hold the accepted beat
  logic                     kind_r;
  logic [ADDR_W-1:0]        addr_r;
  logic signed [DATA_W-1:0] value_r, ca_r, cb_r, cc_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= kind;
      addr_r  <= entry_address;
      value_r <= entry_value;
      ca_r    <= coord_a;
      cb_r    <= coord_b;
      cc_r    <= coord_c;
    end
  end

  // Axis scale: one shared 32x32 multiplier
  logic signed [DATA_W-1:0] x_sel, s_sel;
  logic [DATA_W-1:0]        inv_sel;
  logic [31:0]              lim_sel;
  logic [IDX_W-1:0]         n3_sel, n1_sel;
  logic signed [DATA_W:0]   d_ax;
  logic [DATA_W:0]          d_mag;
  logic [63:0]              mag_r;
  logic                     neg_r;

  always_comb begin
    case (cmd.axis)
      AX_A: begin
        x_sel = ca_r; s_sel = start_a; inv_sel = inv_a;
        lim_sel = 32'(POINTS_A - 1);
        n3_sel = IDX_W'(POINTS_A - 3); n1_sel = IDX_W'(POINTS_A - 1);
      end
      AX_B: begin
        x_sel = cb_r; s_sel = start_b; inv_sel = inv_b;
        lim_sel = 32'(POINTS_B - 1);
        n3_sel = IDX_W'(POINTS_B - 3); n1_sel = IDX_W'(POINTS_B - 1);
      end
      default: begin
        x_sel = cc_r; s_sel = start_c; inv_sel = inv_c;
        lim_sel = 32'(POINTS_C - 1);
        n3_sel = IDX_W'(POINTS_C - 3); n1_sel = IDX_W'(POINTS_C - 1);
      end
    endcase
    d_ax  = {x_sel[DATA_W-1], x_sel} - {s_sel[DATA_W-1], s_sel};
    d_mag = d_ax[DATA_W] ? (~d_ax + 1'b1) : d_ax;
  end

  always_ff @(posedge clk) begin
    if (cmd.ax_mul) begin
      mag_r <= 64'(d_mag[DATA_W-1:0]) * 64'(inv_sel);
      neg_r <= d_ax[DATA_W];
    end
  end

  // Cell index and fraction for the axis in hand
  logic [31:0]           imag;
  logic                  in_cell, below_v;
  logic [IDX_W-1:0]      lo_v, hi_v;
  logic signed [W_W-1:0] w_v;
  logic [W_W-1:0]        ext_v;

  always_comb begin
    imag    = mag_r[63:32];
    below_v = neg_r && (imag != 32'd0);
    in_cell = neg_r || (imag < lim_sel);
    ext_v   = mag_r[63:16] - (W_W'(n3_sel) << 16);
    if (in_cell) begin
      lo_v = neg_r ? '0 : imag[IDX_W-1:0];
      hi_v = lo_v + 1'b1;
      w_v  = neg_r ? -$signed(W_W'(mag_r[31:16])) : $signed(W_W'(mag_r[31:16]));
    end else begin
      lo_v = n3_sel;
      hi_v = n1_sel;
      w_v  = $signed({1'b0, ext_v[W_W-1:1]});
    end
  end

  logic [IDX_W-1:0]      la, ha, lb, hb, lc, hc;
  logic signed [W_W-1:0] wa, wb, wc;
  logic                  below_r;

  always_ff @(posedge clk) begin
    if (cmd.ax_eval) begin
      case (cmd.axis)
        AX_A:    begin la <= lo_v; ha <= hi_v; wa <= w_v; end
        AX_B:    begin lb <= lo_v; hb <= hi_v; wb <= w_v; end
        default: begin lc <= lo_v; hc <= hi_v; wc <= w_v; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      below_r <= 1'b0;
    end else if (cmd.ax_eval && below_v) begin
      below_r <= 1'b1;
    end
  end

  assign stat.below = below_r || (cmd.ax_eval && below_v);

  // Grid memory: one write port, one registered read port
  logic [DATA_W-1:0]  grid [DEPTH];
  logic [DATA_W-1:0]  rdata;
  logic [IDX_W-1:0]   ia, ib, ic;
  logic [31:0]        addr_full;
  logic [ADDR_W-1:0]  rd_addr;

  always_comb begin
    ia        = cmd.corner[0] ? ha : la;
    ib        = cmd.corner[1] ? hb : lb;
    ic        = cmd.corner[2] ? hc : lc;
    addr_full = 32'(ia) * 32'(STRIDE_A) + 32'(ib) * 32'(STRIDE_B) + 32'(ic);
    rd_addr   = addr_full[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      grid[addr_r] <= value_r;
    end
    if (cmd.rd_en) begin
      rdata <= grid[rd_addr];
    end
  end

  // Operand queue: head pair feeds the lerp, results append at the tail
  logic signed [DATA_W-1:0] q [CORNERS];
  logic [QCNT_W-1:0]        qcnt;
  logic signed [DATA_W-1:0] lerp_res;

  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      qcnt <= '0;
    end else if (cmd.push || cmd.l_acc) begin
      qcnt <= qcnt + 1'b1;
    end else if (cmd.l_prep) begin
      qcnt <= qcnt - QCNT_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      q[qcnt[2:0]] <= rdata;
    end else if (cmd.l_acc) begin
      q[qcnt[2:0]] <= lerp_res;
    end else if (cmd.l_prep) begin
      for (int i = 0; i < CORNERS - 2; i++) begin
        q[i] <= q[i+2];
      end
    end
  end

  // Lerp unit: prepare, two half products, combine, accumulate and clamp
  logic signed [W_W-1:0]    w_cur;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DATA_W-1:0] f0_r;
  logic [DIFF_W-1:0]        dabs_r;
  logic [W_W-1:0]           wabs_r;
  logic                     lneg_r;
  logic [PROD_W-1:0]        p0_r, p1_r;
  logic [SUM_W-1:0]         psum;
  logic [DIFF_W-1:0]        dv_r;
  logic                     ovf_r;
  logic signed [DATA_W+2:0] rsum;
  logic                     sat_v, sat_r;

  always_comb begin
    case (cmd.w_sel)
      AX_A:    w_cur = wa;
      AX_B:    w_cur = wb;
      default: w_cur = wc;
    endcase
    diff = {q[1][DATA_W-1], q[1]} - {q[0][DATA_W-1], q[0]};
    psum = SUM_W'({p1_r[HALF_W:0], {HALF_W{1'b0}}}) + SUM_W'(p0_r);
    // the step can reach 2^33, so keep three guard bits over the value
    rsum = lneg_r ? ($signed({{3{f0_r[DATA_W-1]}}, f0_r}) - $signed({2'b0, dv_r}))
                  : ($signed({{3{f0_r[DATA_W-1]}}, f0_r}) + $signed({2'b0, dv_r}));
    if (ovf_r) begin
      sat_v    = 1'b1;
      lerp_res = lneg_r ? MIN_V[DATA_W-1:0] : MAX_V[DATA_W-1:0];
    end else if (rsum > MAX_V) begin
      sat_v    = 1'b1;
      lerp_res = MAX_V[DATA_W-1:0];
    end else if (rsum < MIN_V) begin
      sat_v    = 1'b1;
      lerp_res = MIN_V[DATA_W-1:0];
    end else begin
      sat_v    = 1'b0;
      lerp_res = rsum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.l_prep) begin
      f0_r   <= q[0];
      dabs_r <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      wabs_r <= w_cur[W_W-1] ? W_W'(-w_cur) : W_W'(w_cur);
      lneg_r <= diff[DIFF_W-1] ^ w_cur[W_W-1];
    end
    if (cmd.l_mullo) begin
      p0_r <= PROD_W'(wabs_r[HALF_W-1:0]) * PROD_W'(dabs_r);
    end
    if (cmd.l_mulhi) begin
      p1_r <= PROD_W'(wabs_r[W_W-1:HALF_W]) * PROD_W'(dabs_r);
    end
    if (cmd.l_sum) begin
      ovf_r <= (p1_r[PROD_W-1:HALF_W+1] != '0) || (psum[SUM_W-1:49] != '0);
      dv_r  <= psum[48:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      sat_r <= 1'b0;
    end else if (cmd.l_acc && sat_v) begin
      sat_r <= 1'b1;
    end
  end

  // Output registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (kind_r == KIND_WRITE) begin
        result_value <= '0;
        status       <= STATUS_WRITE;
      end else if (below_r) begin
        result_value <= '0;
        status       <= STATUS_BELOW;
      end else begin
        result_value <= q[0];
        status       <= sat_r ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.push || cmd.l_acc) |-> (qcnt < QCNT_W'(CORNERS)))
    else $error("operand queue overflow");
  a_pair_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.l_prep |-> (qcnt >= QCNT_W'(2))) else $error("lerp started without a pair");
  a_no_rw: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_wr && cmd.rd_en)) else $error("table write during corner fetch");

endmodule

/* hdl/trilinear_interp_3d_table.sv */
// Top level of the 3D grid table with trilinear interpolation.
// Usage:
//   Raise start with an item; it is taken on an edge where busy is low.
//   kind 0 writes entry_value at entry_address; kind 1 queries the point
//   (coord_a, coord_b, coord_c) in signed Q16.16.
//   One result beat per item: result_value and status valid while done is
//   high, for exactly one cycle; the receiver cannot stall it.
//   Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Sequence: a write stores its entry and then finishes; a query below the grid
//   finishes after the three axis scalings; a full query does the three axis
//   scalings on one shared multiplier, eight corner reads through the single
//   table read port, seven lerps on one lerp unit (two half-width products),
//   and then finishes.
//   A new item may be started in the done cycle; no new item is taken while
//   busy is high.
// Reset: synchronous rst returns the sequencer to idle and the registers to
//   start 0, inverse spacing 1.0; the table is not cleared and must be
//   written before it is read.
module trilinear_interp_3d_table
  import tri3d_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output logic                     done,
  input  logic                     kind,
  input  logic [ADDR_W-1:0]        entry_address,
  input  logic signed [DATA_W-1:0] entry_value,
  input  logic signed [DATA_W-1:0] coord_a,
  input  logic signed [DATA_W-1:0] coord_b,
  input  logic signed [DATA_W-1:0] coord_c,
  output logic signed [DATA_W-1:0] result_value,
  output logic [1:0]               status,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  tri_cmd_t  cmd;
  tri_stat_t stat;

  tri3d_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  tri3d_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .entry_address (entry_address),
    .entry_value   (entry_value),
    .coord_a       (coord_a),
    .coord_b       (coord_b),
    .coord_c       (coord_c),
    .result_value  (result_value),
    .status        (status)
  );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the 3D grid table with trilinear interpolation.
`timescale 1ns / 100ps
module tb;
  import tri3d_pkg::*;

  localparam int QUERY_CYCLES = 52;
  localparam int STALL_LIMIT  = 2000;
  localparam int FILL_LOW     = 4;

  typedef struct {
    logic signed [31:0] value;
    status_t            code;
  } interp_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     done;
  logic                     kind = 1'b0;
  logic [ADDR_W-1:0]        entry_address = '0;
  logic signed [DATA_W-1:0] entry_value = '0;
  logic signed [DATA_W-1:0] coord_a = '0;
  logic signed [DATA_W-1:0] coord_b = '0;
  logic signed [DATA_W-1:0] coord_c = '0;
  logic signed [DATA_W-1:0] result_value;
  logic [1:0]               status;
  logic                     cfg_we = 1'b0;
  logic [2:0]               cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  // Testbench copy of the table and of the axis registers
  logic [31:0]    grid_mem [DEPTH];
  bit             written [DEPTH];
  logic [31:0]    axis_start [3];
  logic [31:0]    axis_inv [3];
  interp_result_t pending_q [$];
  int             mismatches = 0;
  int             stall_cycles = 0;
  bit             gaps_on = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  trilinear_interp_3d_table i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .kind(kind), .entry_address(entry_address), .entry_value(entry_value),
    .coord_a(coord_a), .coord_b(coord_b), .coord_c(coord_c),
    .result_value(result_value), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // Map one coordinate to its cell and fraction; return 0 below the grid
  function automatic bit axis_cell(input logic [31:0] x, input logic [31:0] org,
                                   input logic [31:0] inv, input int npts,
                                   output int lo, output int hi, output longint w);
    longint      d;
    bit          neg;
    logic [63:0] dm;
    logic [63:0] mag;
    logic [63:0] idx;
    longint      t16;
    lo = 0;
    hi = 0;
    w  = 0;
    d   = sx32(x) - sx32(org);
    neg = d < 0;
    dm  = neg ? 64'(-d) : 64'(d);
    mag = dm * {32'b0, inv};
    t16 = neg ? -longint'(mag >> 16) : longint'(mag >> 16);
    if (neg && (mag >> 32) != 0) return 1'b0;
    idx = neg ? 64'd0 : (mag >> 32);
    if (idx < 64'(npts - 1)) begin
      lo = int'(idx);
      hi = lo + 1;
      w  = t16 - longint'(idx) * 65536;
    end else begin
      // extrapolate from the last grid point pair two apart, halved fraction
      lo = npts - 3;
      hi = npts - 1;
      w  = longint'(64'(t16 - longint'(npts - 3) * 65536) >> 1);
    end
    return 1'b1;
  endfunction

  // One clamped linear step from f0 toward f1 by fraction w
  function automatic longint lerp_clamped(input longint f0, input longint f1,
                                          input longint w, inout bit sat);
    longint       diff;
    bit           neg;
    logic [127:0] prod;
    longint       r;
    diff = f1 - f0;
    neg  = (diff < 0) != (w < 0);
    prod = {64'b0, 64'(w < 0 ? -w : w)} * {64'b0, 64'(diff < 0 ? -diff : diff)};
    if ((prod >> 16) >= (128'd1 << 33))
      r = neg ? -64'sd2147483649 : 64'sd2147483648;
    else
      r = neg ? f0 - longint'(prod[79:16]) : f0 + longint'(prod[79:16]);
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      sat = 1'b1;
    end
    if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      sat = 1'b1;
    end
    return r;
  endfunction

  function automatic longint grid_at(int ia, int ib, int ic);
    return sx32(grid_mem[(ia * STRIDE_A + ib * STRIDE_B + ic) % DEPTH]);
  endfunction

  // True when a query at this point would read a table entry never written
  function automatic bit reads_unwritten(logic [31:0] xa, logic [31:0] xb,
                                         logic [31:0] xc);
    int     la, ha, lb, hb, lc, hc;
    longint wa, wb, wc;
    bit     ok;
    ok = axis_cell(xa, axis_start[0], axis_inv[0], POINTS_A, la, ha, wa);
    ok = axis_cell(xb, axis_start[1], axis_inv[1], POINTS_B, lb, hb, wb) && ok;
    ok = axis_cell(xc, axis_start[2], axis_inv[2], POINTS_C, lc, hc, wc) && ok;
    if (!ok) return 1'b0;
    for (int p = 0; p < 2; p++)
      for (int q = 0; q < 2; q++)
        for (int r = 0; r < 2; r++)
          if (!written[((p ? ha : la) * STRIDE_A + (q ? hb : lb) * STRIDE_B +
                        (r ? hc : lc)) % DEPTH])
            return 1'b1;
    return 1'b0;
  endfunction

  // Work out the result of one accepted beat and update the table copy
  function automatic interp_result_t interp_predict(logic k, logic [11:0] addr,
      logic [31:0] val, logic [31:0] xa, logic [31:0] xb, logic [31:0] xc);
    interp_result_t res;
    int             la, ha, lb, hb, lc, hc;
    longint         wa, wb, wc;
    longint         fa [2][2];
    longint         fb [2];
    bit             ok;
    bit             sat;
    sat = 1'b0;
    if (k == KIND_WRITE) begin
      grid_mem[addr] = val;
      written[addr]  = 1'b1;
      res.value = '0;
      res.code  = STATUS_WRITE;
      return res;
    end
    ok = axis_cell(xa, axis_start[0], axis_inv[0], POINTS_A, la, ha, wa);
    ok = axis_cell(xb, axis_start[1], axis_inv[1], POINTS_B, lb, hb, wb) && ok;
    ok = axis_cell(xc, axis_start[2], axis_inv[2], POINTS_C, lc, hc, wc) && ok;
    if (!ok) begin
      res.value = '0;
      res.code  = STATUS_BELOW;
      return res;
    end
    for (int q = 0; q < 2; q++)
      for (int r = 0; r < 2; r++)
        fa[q][r] = lerp_clamped(grid_at(la, q ? hb : lb, r ? hc : lc),
                                grid_at(ha, q ? hb : lb, r ? hc : lc), wa, sat);
    for (int r = 0; r < 2; r++)
      fb[r] = lerp_clamped(fa[0][r], fa[1][r], wb, sat);
    res.value = 32'(lerp_clamped(fb[0], fb[1], wc, sat));
    res.code  = sat ? STATUS_SAT : STATUS_OK;
    return res;
  endfunction

  // Check each result beat against the oldest prediction; watch for stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: value %h status %0d", result_value, status);
        end else begin
          if (result_value !== pending_q[0].value || status !== pending_q[0].code) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %h status %0d, got value %h status %0d",
                       pending_q[0].value, pending_q[0].code, result_value, status);
          end
          void'(pending_q.pop_front());
        end
      end
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Drive one beat and hold it until the block takes it; start stays high
  task automatic send_item(logic k, logic [11:0] addr, logic [31:0] val,
                           logic [31:0] xa, logic [31:0] xb, logic [31:0] xc);
    interp_result_t res;
    if (gaps_on && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start         <= 1'b1;
    kind          <= k;
    entry_address <= addr;
    entry_value   <= val;
    coord_a       <= xa;
    coord_b       <= xb;
    coord_c       <= xc;
    @(posedge clk);
    while (busy) @(posedge clk);
    res       = interp_predict(k, addr, val, xa, xb, xc);
    pending_q = {pending_q, res};
  endtask

  task automatic write_entry(int addr, logic [31:0] val);
    send_item(KIND_WRITE, 12'(addr), val, $urandom, $urandom, $urandom);
  endtask

  task automatic query_point(logic [31:0] xa, logic [31:0] xb, logic [31:0] xc);
    send_item(KIND_QUERY, 12'($urandom), $urandom, xa, xb, xc);
  endtask

  // Drop start and let every outstanding result arrive
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (QUERY_CYCLES + 8) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_START_C) axis_start[int'(idx)] = val;
    else axis_inv[int'(idx) - int'(REG_INV_A)] = val;
  endtask

  task automatic set_axes(logic [31:0] org, logic [31:0] inv);
    set_reg(REG_START_A, org);
    set_reg(REG_START_B, org + 32'h0001_8000);
    set_reg(REG_START_C, org - 32'h0000_4000);
    set_reg(REG_INV_A, inv);
    set_reg(REG_INV_B, inv);
    set_reg(REG_INV_C, inv);
  endtask

  // Coordinate somewhere over the grid on one axis, a little past each end
  function automatic logic [31:0] grid_coord(int ax);
    longint span;
    span = longint'($urandom_range(0, 19 * 65536)) - 65536;
    if (axis_inv[ax] == 0) return $urandom;
    return 32'(sx32(axis_start[ax]) + span * 65536 / longint'(axis_inv[ax]));
  endfunction

  // Random point over the grid that reads only written entries
  task automatic query_grid();
    logic [31:0] xa, xb, xc;
    int          tries;
    tries = 0;
    do begin
      xa = grid_coord(0);
      xb = grid_coord(1);
      xc = grid_coord(2);
      tries++;
    end while (reads_unwritten(xa, xb, xc) && tries < 64);
    // fall back to the grid origin, which always reads written entries
    if (reads_unwritten(xa, xb, xc)) begin
      xa = axis_start[0];
      xb = axis_start[1];
      xc = axis_start[2];
    end
    query_point(xa, xb, xc);
  endtask

  task automatic random_mix(int count);
    int          pick;
    logic        k;
    logic [31:0] xa, xb, xc;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        query_grid();
      else if (pick < 85)
        write_entry($urandom_range(0, DEPTH - 1), $urandom_range(0, 1 << 22) - (1 << 21));
      else begin
        k  = 1'($urandom_range(0, 1));
        xa = $urandom;
        xb = $urandom;
        xc = $urandom;
        // turn a query that would touch unwritten entries into a write
        if (k == KIND_QUERY && reads_unwritten(xa, xb, xc)) k = KIND_WRITE;
        send_item(k, 12'($urandom), $urandom, xa, xb, xc);
      end
    end
  endtask

  function automatic bit fill_point(int i, int npts);
    return (i <= FILL_LOW) || (i >= npts - 3);
  endfunction

  // Write the low grid points and the last three on each axis; queries stay there
  task automatic test_fill_table();
    for (int ia = 0; ia < POINTS_A; ia++)
      for (int ib = 0; ib < POINTS_B; ib++)
        for (int ic = 0; ic < POINTS_C; ic++)
          if (fill_point(ia, POINTS_A) && fill_point(ib, POINTS_B) &&
              fill_point(ic, POINTS_C))
            write_entry(ia * STRIDE_A + ib * STRIDE_B + ic,
                        $urandom_range(0, 1 << 24) - (1 << 23));
    drain();
  endtask

  task automatic test_directed();
    query_point(32'h0, 32'h0, 32'h0);
    query_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    query_point(32'h0002_8000, 32'h0003_4000, 32'h000d_c000);
    // upper end of each axis: last cell on axis a, extrapolation past it on b and c
    query_point(32'h000e_8000, 32'h000f_0000, 32'h0011_8000);
    query_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    // below the grid, and a position just under zero that still extrapolates
    query_point(32'hfffe_8000, 32'h0001_0000, 32'h0001_0000);
    query_point(32'h0001_0000, 32'h8000_0000, 32'h0001_0000);
    query_point(32'hffff_8000, 32'hffff_c000, 32'hffff_0001);
    // extreme table values push lerps into saturation
    write_entry(0, 32'h7fff_ffff);
    write_entry(STRIDE_A, 32'h8000_0000);
    write_entry(STRIDE_B, 32'h8000_0000);
    write_entry(1, 32'h7fff_ffff);
    write_entry(DEPTH - 1, 32'h8000_0000);
    query_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    query_point(32'hffff_8000, 32'h0000_0000, 32'h0000_0000);
    query_point(32'h0000_0000, 32'hffff_8000, 32'h0000_4000);
    query_point(32'h000f_0000, 32'h000f_0000, 32'h000f_0000);
    drain();
    // zero inverse spacing pins everything to cell 0
    set_axes(32'h8000_0000, 32'h0);
    query_point(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
    query_point(32'h0, 32'hffff_ffff, 32'h0);
    drain();
    // widest inverse spacing
    set_axes(32'h7fff_ffff, 32'hffff_ffff);
    query_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    query_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
  endtask

  task automatic test_config_sweep();
    logic [31:0] orgs [5] = '{32'h0, 32'hfff8_0000, 32'h8000_0000, 32'h0003_4000, 32'h7fff_0000};
    logic [31:0] invs [5] = '{32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'hffff_ffff,
                              32'h0000_0001};
    for (int s = 0; s < 5; s++) begin
      set_axes(orgs[s], invs[s]);
      random_mix(60);
      drain();
    end
  endtask

  task automatic test_random();
    set_axes(32'hffff_0000, 32'h0001_0000);
    random_mix(350);
    // a stretch with no gaps at all
    gaps_on = 1'b0;
    random_mix(330);
    gaps_on = 1'b1;
    drain();
    set_axes(32'h0000_8000, 32'h0000_c000);
    random_mix(330);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    axis_start = '{32'h0, 32'h0, 32'h0};
    axis_inv   = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    @(posedge clk);
    test_fill_table();
    test_directed();
    test_config_sweep();
    test_random();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* trilinear_interp_3d_table.f */
hdl/tri3d_pkg.sv
hdl/tri3d_ctrl.sv
hdl/tri3d_dp.sv
hdl/trilinear_interp_3d_table.sv
tb/sv/tb.sv
